@@ rtl/ptm_pkg.sv @@
// Package for the page table mapper: sizes, codes, entry flags and the
// structs passed between the sequencer, the shared adder and the table store.
// No dependencies.
`default_nettype none

package ptm_pkg;

  localparam int POOL_PAGES  = 16;
  localparam int VPN_W       = 9;
  localparam int ENTRIES     = 1 << VPN_W;
  localparam int PAGE_W      = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int NF_W        = $clog2(POOL_PAGES + 1);
  localparam int ADDR_W      = PAGE_W + VPN_W;
  localparam int STORE_DEPTH = POOL_PAGES * ENTRIES;

  localparam int ENTRY_W  = 64;
  localparam int MEM_W    = ENTRY_W + 1;
  localparam int PAGE_OFS = 12;
  localparam int VA_W     = 39;
  localparam int BEGIN_W  = 40;
  localparam int PA_W     = 56;
  localparam int LEN_W    = 32;
  localparam int FLAG_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 21;
  localparam int PPN_W    = 44;
  localparam int ALU_W    = 56;
  localparam int CFG_W    = 44;
  localparam int CFG_IDX_W = 1;

  localparam logic [BEGIN_W-1:0] VA_LIMIT_RST = 40'h40_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_VA_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_BAD   = 3'd1;
  localparam status_t ST_RANGE = 3'd2;
  localparam status_t ST_POOL  = 3'd3;
  localparam status_t ST_REMAP = 3'd4;

  localparam logic [FLAG_W-1:0] F_V = 8'h01;
  localparam logic [FLAG_W-1:0] F_A = 8'h40;
  localparam logic [FLAG_W-1:0] F_D = 8'h80;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             carry;
    logic [ALU_W-1:0] sum;
  } alu_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MEM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [LEN_W-1:0]  map_length;
    logic [FLAG_W-1:0] perm_flags;
  } map_req_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] pages_mapped;
  } map_rsp_t;

endpackage

`default_nettype wire

@@ rtl/ptm_ifs.sv @@
// Valid/ready channel interfaces for mapping requests and results.
// Depends on ptm_pkg.
`default_nettype none

interface ptm_req_if import ptm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VA_W-1:0]   virt_addr;
  logic [PA_W-1:0]   phys_addr;
  logic [LEN_W-1:0]  map_length;
  logic [FLAG_W-1:0] perm_flags;

  modport source (output valid, virt_addr, phys_addr, map_length, perm_flags,
                  input ready);
  modport sink (input valid, virt_addr, phys_addr, map_length, perm_flags,
                output ready);
endinterface

interface ptm_rsp_if import ptm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] pages_mapped;

  modport source (output valid, status, pages_mapped, input ready);
  modport sink (input valid, status, pages_mapped, output ready);
endinterface

`default_nettype wire

@@ rtl/ptm_alu.sv @@
// Shared 56-bit add/subtract unit with carry out, used for the wide sums
// of the mapper and for its limit compare. Depends on ptm_pkg.
`default_nettype none

module ptm_alu import ptm_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] total;

  assign total = {1'b0, req.a} + {1'b0, req.b ^ {ALU_W{req.sub}}} + (ALU_W + 1)'(req.sub);
  assign rsp.carry = total[ALU_W];
  assign rsp.sum   = total[ALU_W-1:0];

endmodule

`default_nettype wire

@@ rtl/ptm_store.sv @@
// Table page pool: one write port, one registered read port. Each word
// holds a 64-bit entry and an allocation mark bit. Depends on ptm_pkg.
`default_nettype none

module ptm_store import ptm_pkg::*; (
  input  logic             clk,
  input  mem_req_t         req,
  output logic [MEM_W-1:0] rdata
);

  logic [MEM_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptm_seq.sv @@
// Sequencer of the mapper: clearing pass, parameter check, per-page walk,
// allocation and leaf write, wide sums in the shared adder. Depends on ptm_pkg.
`default_nettype none

module ptm_seq import ptm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  map_req_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output map_rsp_t           out_item,
  input  logic [BEGIN_W-1:0] va_limit,
  input  logic [PPN_W-1:0]   table_base,
  output mem_req_t           mem,
  input  logic [MEM_W-1:0]   rdata,
  output alu_req_t           alu_req,
  input  alu_rsp_t           alu_rsp
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LIMIT  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_ADV_VA = 3'd5;
  localparam logic [2:0] S_ADV_PA = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam logic [ALU_W-1:0] PAGE_BYTES = ALU_W'(1) << PAGE_OFS;
  localparam logic [ALU_W-1:0] PAGE_MASK  = PAGE_BYTES - ALU_W'(1);

  logic [2:0]          state, state_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [NF_W-1:0]     next_free, next_free_next;
  logic [BEGIN_W-1:0]  begin_va, begin_va_next;
  logic [PA_W-1:0]     pa, pa_next;
  logic [FLAG_W-1:0]   flags, flags_next;
  logic [COUNT_W-1:0]  total, total_next;
  logic [COUNT_W-1:0]  count, count_next;
  logic [PAGE_W-1:0]   page, page_next;
  logic [1:0]          level, level_next;
  status_t             status, status_next;

  logic [VPN_W-1:0]    vpn;
  logic [ADDR_W-1:0]   slot;
  logic                page_alloc;
  logic                page_alloc_after;
  logic                eff_v;
  logic                pool_full;
  logic [PPN_W-1:0]    rel;
  logic                stale;
  logic                bad;
  logic [COUNT_W-1:0]  count_inc;

  always_comb begin
    unique case (level)
      2'd2:    vpn = begin_va[PAGE_OFS + 2*VPN_W +: VPN_W];
      2'd1:    vpn = begin_va[PAGE_OFS + VPN_W +: VPN_W];
      default: vpn = begin_va[PAGE_OFS +: VPN_W];
    endcase
  end

  assign slot             = {page, vpn};
  assign page_alloc       = NF_W'(page) < next_free;
  assign page_alloc_after = NF_W'(page) <= next_free;
  assign eff_v            = rdata[0] & (rdata[MEM_W-1] == page_alloc);
  assign pool_full        = next_free == NF_W'(POOL_PAGES);
  assign rel              = alu_rsp.sum[PPN_W-1:0];
  assign stale            = rel >= PPN_W'(POOL_PAGES);
  assign count_inc        = count + COUNT_W'(1);
  assign bad = (in_item.map_length == '0) || (in_item.virt_addr[PAGE_OFS-1:0] != '0) ||
               (in_item.phys_addr[PAGE_OFS-1:0] != '0);

  always_comb begin
    alu_req.sub = ALU_ADD;
    alu_req.a   = '0;
    alu_req.b   = '0;
    unique case (state)
      S_IDLE: begin
        alu_req.a = ALU_W'(in_item.map_length);
        alu_req.b = PAGE_MASK;
      end
      S_LIMIT: begin
        alu_req.sub = ALU_SUB;
        alu_req.a   = ALU_W'(begin_va);
        alu_req.b   = ALU_W'(va_limit);
      end
      S_EVAL: begin
        if (eff_v) begin
          alu_req.sub = ALU_SUB;
          alu_req.a   = ALU_W'(rdata[PPN_W+9:10]);
          alu_req.b   = ALU_W'(table_base);
        end else begin
          alu_req.a = ALU_W'(table_base);
          alu_req.b = ALU_W'(next_free);
        end
      end
      S_ADV_VA: begin
        alu_req.a = ALU_W'(begin_va);
        alu_req.b = PAGE_BYTES;
      end
      S_ADV_PA: begin
        alu_req.a = pa;
        alu_req.b = PAGE_BYTES;
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
  end

  always_comb begin
    mem.we    = 1'b0;
    mem.waddr = slot;
    mem.wdata = '0;
    mem.re    = 1'b0;
    mem.raddr = slot;
    unique case (state)
      S_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = clr_addr;
      end
      S_READ: begin
        mem.re = 1'b1;
      end
      S_EVAL: begin
        if (level != 2'd0) begin
          mem.we    = !eff_v && !pool_full;
          mem.wdata = {page_alloc_after, 10'b0, rel ^ rel ^ alu_rsp.sum[PPN_W-1:0],
                       2'b0, F_V};
        end else begin
          mem.we    = !eff_v;
          mem.wdata = {page_alloc, 10'b0, pa[PA_W-1:PAGE_OFS], 2'b0,
                       flags | F_V | F_A | F_D};
        end
      end
      default: begin
        mem.we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    next_free_next = next_free;
    begin_va_next  = begin_va;
    pa_next        = pa;
    flags_next     = flags;
    total_next     = total;
    count_next     = count;
    page_next      = page;
    level_next     = level;
    status_next    = status;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    unique case (state)
      S_CLEAR: begin
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          begin_va_next = BEGIN_W'(in_item.virt_addr);
          pa_next       = in_item.phys_addr;
          flags_next    = in_item.perm_flags;
          total_next    = alu_rsp.sum[PAGE_OFS +: COUNT_W];
          count_next    = '0;
          if (bad) begin
            status_next = ST_BAD;
            state_next  = S_DONE;
          end else begin
            state_next = S_LIMIT;
          end
        end
      end
      S_LIMIT: begin
        if (alu_rsp.carry) begin
          status_next = ST_RANGE;
          state_next  = S_DONE;
        end else begin
          level_next = 2'd2;
          page_next  = '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (level != 2'd0) begin
          if (eff_v) begin
            if (stale) begin
              status_next = ST_POOL;
              state_next  = S_DONE;
            end else begin
              page_next  = rel[PAGE_W-1:0];
              level_next = level - 2'd1;
              state_next = S_READ;
            end
          end else if (pool_full) begin
            status_next = ST_POOL;
            state_next  = S_DONE;
          end else begin
            page_next      = next_free[PAGE_W-1:0];
            next_free_next = next_free + NF_W'(1);
            level_next     = level - 2'd1;
            state_next     = S_READ;
          end
        end else if (eff_v) begin
          status_next = ST_REMAP;
          state_next  = S_DONE;
        end else begin
          count_next = count_inc;
          if (count_inc == total) begin
            status_next = ST_OK;
            state_next  = S_DONE;
          end else begin
            state_next = S_ADV_VA;
          end
        end
      end
      S_ADV_VA: begin
        begin_va_next = alu_rsp.sum[BEGIN_W-1:0];
        state_next    = S_ADV_PA;
      end
      S_ADV_PA: begin
        pa_next    = alu_rsp.sum[PA_W-1:0];
        state_next = S_LIMIT;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_item.status       = status;
  assign out_item.pages_mapped = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      next_free <= NF_W'(1);
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      next_free <= next_free_next;
    end
    begin_va <= begin_va_next;
    pa       <= pa_next;
    flags    <= flags_next;
    total    <= total_next;
    count    <= count_next;
    page     <= page_next;
    level    <= level_next;
    status   <= status_next;
  end

endmodule

`default_nettype wire

@@ rtl/page_table_mapper_unit.sv @@
// Top level of the page table mapper: configuration registers, result
// register and the sequencer, shared adder and table store.
// Depends on ptm_pkg, ptm_ifs, ptm_alu, ptm_store, ptm_seq.
//
//   channel  dir  payload                                     handshake
//   req      in   virt_addr, phys_addr, map_length, flags     valid/ready
//   rsp      out  status, pages_mapped                        valid/ready
//   cfg      in   cfg_index, cfg_wdata                        cfg_we
//
// A rejected request passes through acceptance and result hand-off. A
// request that maps n pages and ends well takes, per page, a limit check,
// three read/evaluate pairs and, for every page but the last, two address
// updates, all through the one adder and the single store port. A run that
// stops early goes to the done state after the failing check. After reset
// all 8192 store entries are cleared, one entry a cycle; req.ready stays
// low meanwhile. One item is in work at a time; a waiting result sits in
// the output register while the next item is accepted.
`default_nettype none

module page_table_mapper_unit import ptm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  ptm_req_if.sink                   req,
  ptm_rsp_if.source                 rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [BEGIN_W-1:0] va_limit;
  logic [PPN_W-1:0]   table_base;
  map_req_t           in_item;
  map_rsp_t           done_item;
  logic               done_valid;
  logic               out_free;
  logic               out_valid;
  map_rsp_t           out_item;
  mem_req_t           mem;
  logic [MEM_W-1:0]   rdata;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      va_limit   <= VA_LIMIT_RST;
      table_base <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VA_LIMIT:   va_limit   <= cfg_wdata[BEGIN_W-1:0];
        CFG_TABLE_BASE: table_base <= cfg_wdata[PPN_W-1:0];
        default:        va_limit   <= va_limit;
      endcase
    end
  end

  assign in_item.virt_addr  = req.virt_addr;
  assign in_item.phys_addr  = req.phys_addr;
  assign in_item.map_length = req.map_length;
  assign in_item.perm_flags = req.perm_flags;

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= done_valid;
    end
    if (out_free && done_valid) begin
      out_item <= done_item;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_item.status;
  assign rsp.pages_mapped = out_item.pages_mapped;

  ptm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ptm_store u_store (
    .clk   (clk),
    .req   (mem),
    .rdata (rdata)
  );

  ptm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_item    (in_item),
    .out_valid  (done_valid),
    .out_ready  (out_free),
    .out_item   (done_item),
    .va_limit   (va_limit),
    .table_base (table_base),
    .mem        (mem),
    .rdata      (rdata),
    .alu_req    (alu_req),
    .alu_rsp    (alu_rsp)
  );

endmodule

`default_nettype wire

@@ dv/page_table_mapper_unit_tb.sv @@
// Testbench for page_table_mapper_unit: random and directed mapping requests
// checked against a behavioral page-table predictor held in a scoreboard class.
// Depends on ptm_pkg, ptm_ifs and the page_table_mapper_unit RTL.
`timescale 1ns / 1ps

module page_table_mapper_unit_tb;
  import ptm_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 400;

  class mapping_scoreboard;
    bit [ENTRY_W-1:0] tables [STORE_DEPTH];
    int unsigned      free_page;
    bit [BEGIN_W-1:0] va_limit;
    bit [PPN_W-1:0]   table_base;
    map_rsp_t         pending_results [$];
    int unsigned      errors;

    function new();
      foreach (tables[i]) tables[i] = '0;
      free_page  = 1;
      va_limit   = VA_LIMIT_RST;
      table_base = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_VA_LIMIT) va_limit = val[BEGIN_W-1:0];
      else if (idx == CFG_TABLE_BASE) table_base = val[PPN_W-1:0];
    endfunction

    // Walk levels 2 and 1; return the store index of the leaf or -1.
    function int find_leaf(bit [63:0] va, output status_t err);
      int unsigned    page_idx;
      int unsigned    slot;
      int unsigned    fresh;
      bit [PPN_W-1:0] rel;
      page_idx = 0;
      err = ST_OK;
      for (int lvl = 2; lvl > 0; lvl--) begin
        slot = page_idx * ENTRIES + int'((va >> (PAGE_OFS + VPN_W * lvl)) & 64'h1ff);
        if (tables[slot][0]) begin
          rel = tables[slot][53:10] - table_base;
          if (rel >= POOL_PAGES) begin
            err = ST_POOL;
            return -1;
          end
          page_idx = int'(rel);
        end else begin
          if (free_page >= POOL_PAGES) begin
            err = ST_POOL;
            return -1;
          end
          fresh = free_page;
          free_page++;
          for (int i = 0; i < ENTRIES; i++) tables[fresh * ENTRIES + i] = '0;
          tables[slot] = '0;
          tables[slot][53:10] = table_base + PPN_W'(fresh);
          tables[slot][0] = 1'b1;
          page_idx = fresh;
        end
      end
      return int'(page_idx * ENTRIES + int'(va[20:12]));
    endfunction

    function void note_request(map_req_t r);
      bit [63:0]          cur;
      bit [63:0]          last_page;
      bit [PA_W-1:0]      pa;
      bit [ENTRY_W-1:0]   leaf_ent;
      status_t            st;
      status_t            err;
      bit [COUNT_W-1:0]   count;
      int                 leaf;
      bit                 done;
      map_rsp_t           res;
      st = ST_OK;
      count = '0;
      if (r.map_length == 0 || r.virt_addr[11:0] != 0 || r.phys_addr[11:0] != 0) begin
        st = ST_BAD;
      end else begin
        cur = 64'(r.virt_addr);
        pa = r.phys_addr;
        last_page = (cur + 64'(r.map_length) - 64'd1) & ~64'hfff;
        done = 1'b0;
        while (!done) begin
          if (cur >= 64'(va_limit)) begin
            st = ST_RANGE;
            done = 1'b1;
          end else begin
            leaf = find_leaf(cur, err);
            if (leaf < 0) begin
              st = err;
              done = 1'b1;
            end else if (tables[leaf][0]) begin
              st = ST_REMAP;
              done = 1'b1;
            end else begin
              leaf_ent = '0;
              leaf_ent[53:10] = pa[PA_W-1:PAGE_OFS];
              leaf_ent[7:0] = r.perm_flags | F_V | F_A | F_D;
              tables[leaf] = leaf_ent;
              count++;
              if (cur == last_page) done = 1'b1;
              cur += 64'h1000;
              pa += PA_W'(64'h1000);
            end
          end
        end
      end
      res.status = st;
      res.pages_mapped = count;
      pending_results.push_back(res);
    endfunction

    function void check_result(status_t st, logic [COUNT_W-1:0] count);
      map_rsp_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d pages_mapped %0d", st, count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (count !== want.pages_mapped) begin
        $error("pages_mapped: expected %0d, actual %0d", want.pages_mapped, count);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ptm_req_if req_ch ();
  ptm_rsp_if rsp_ch ();

  mapping_scoreboard mappings = new();

  int unsigned n_sent    = 0;
  int unsigned n_results = 0;
  int unsigned cycles    = 0;
  bit          gaps_on   = 1'b1;

  page_table_mapper_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic map_req_t map_req(logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                       logic [LEN_W-1:0] len, logic [FLAG_W-1:0] flags);
    map_req_t r;
    r.virt_addr  = va;
    r.phys_addr  = pa;
    r.map_length = len;
    r.perm_flags = flags;
    return r;
  endfunction

  function automatic map_req_t random_map_req();
    map_req_t  r;
    int        kind;
    int        k;
    bit [8:0]  l2;
    bit [8:0]  l1;
    bit [63:0] top;
    kind = $urandom_range(0, 99);
    r.phys_addr = PA_W'({$urandom, $urandom});
    r.phys_addr[11:0] = '0;
    r.perm_flags = FLAG_W'($urandom);
    r.map_length = LEN_W'($urandom);
    r.virt_addr = VA_W'({$urandom, $urandom});
    if (kind < 8) begin
      r.phys_addr = PA_W'({$urandom, $urandom});
      case ($urandom_range(0, 2))
        0: r.map_length = '0;
        1: if (r.virt_addr[11:0] == 0) r.virt_addr[$urandom_range(0, 11)] = 1'b1;
        default: if (r.phys_addr[11:0] == 0) r.phys_addr[$urandom_range(0, 11)] = 1'b1;
      endcase
    end else if (kind < 16) begin
      // aim just below the limit so any length stops within a few pages
      top = 64'(mappings.va_limit) & ~64'hfff;
      k = $urandom_range(0, 8);
      top = (top >= 64'(k * 4096)) ? top - 64'(k * 4096) : 64'd0;
      if (top > 64'h7F_FFFF_F000) top = 64'h7F_FFFF_F000;
      r.virt_addr = top[VA_W-1:0];
    end else begin
      case ($urandom_range(0, 3))
        0: l2 = 9'd0;
        1: l2 = 9'd255;
        2: l2 = 9'd256;
        default: l2 = 9'd511;
      endcase
      case ($urandom_range(0, 2))
        0: l1 = 9'd0;
        1: l1 = 9'd1;
        default: l1 = 9'd511;
      endcase
      if (kind < 18) begin
        l1 = 9'($urandom_range(0, 511));
        r.map_length = LEN_W'($urandom_range(600, 1100) << 12);
      end else if ($urandom_range(0, 3) == 0) begin
        r.map_length = LEN_W'($urandom_range(1, 16 * 4096));
      end else begin
        r.map_length = LEN_W'($urandom_range(1, 3 * 4096));
      end
      r.virt_addr = {l2, l1, 9'($urandom_range(0, 511)), 12'h000};
    end
    return r;
  endfunction

  task automatic send_map(input map_req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.virt_addr  <= r.virt_addr;
    req_ch.phys_addr  <= r.phys_addr;
    req_ch.map_length <= r.map_length;
    req_ch.perm_flags <= r.perm_flags;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    mappings.note_request(r);
    n_sent++;
    gaps_on = ((n_sent / 40) % 3) != 2;
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_map(random_map_req());
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (mappings.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    mappings.set_reg(idx, val);
  endtask

  initial begin : result_sink
    int gap;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      // hold off once so the block fills up and stalls its input
      if (n_results == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      mappings.check_result(rsp_ch.status, rsp_ch.pages_mapped);
      n_results++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("page_table_mapper_unit_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_VA_LIMIT;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.virt_addr  = '0;
    req_ch.phys_addr  = '0;
    req_ch.map_length = '0;
    req_ch.perm_flags = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_map(map_req(39'h0, 56'h0, 32'h0, 8'h0F));
    send_map(map_req(39'h800, 56'h0, 32'h1000, 8'h00));
    send_map(map_req(39'h0, 56'h10, 32'h1000, 8'h00));
    send_map(map_req(39'h0, 56'h0, 32'h1, 8'h00));
    send_map(map_req(39'h0, 56'h5000, 32'h1000, 8'h0E));
    send_map(map_req(39'h1000, 56'hFF_FFFF_FFFF_F000, 32'h2000, 8'hFF));
    send_map(map_req(39'h10000, 56'h123000, 32'h1001, 8'h02));
    send_map(map_req(39'h20000, 56'h200000, 32'h1000, 8'h06));
    send_map(map_req(39'h1FF000, 56'h300000, 32'h2000, 8'h0A));
    send_map(map_req(39'h40_0000_0000, 56'h0, 32'h1000, 8'h02));
    send_map(map_req(39'h3F_FFFF_E000, 56'h400000, 32'h4000, 8'h12));
    send_map(map_req(39'hF000, 56'h500000, 32'h3000, 8'h04));
    send_map(map_req(39'h3F_FFFF_D000, 56'h600000, 32'hFFFF_FFFF, 8'h20));
    send_map(map_req(39'h7F_FFFF_F000, 56'h0, 32'h1000, 8'h01));
    send_map(map_req(39'h3000, 56'h7000, 32'hFFFF_FFFF, 8'h0E));
    send_map(map_req(39'h7F_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    send_map(map_req(39'h4000_0000, 56'h800000, 32'h1000, 8'h0C));
    req_ch.valid <= 1'b0;
    run_random(250);

    wait_idle();
    write_reg(CFG_VA_LIMIT, CFG_W'(40'h0));
    run_random(20);

    wait_idle();
    write_reg(CFG_VA_LIMIT, CFG_W'(40'h80_0000_0000));
    run_random(90);

    wait_idle();
    write_reg(CFG_TABLE_BASE, CFG_W'(44'hFFF_FFFF_FFFF));
    write_reg(CFG_VA_LIMIT, CFG_W'(40'h4000_0000 + 40'($urandom)));
    run_random(80);

    wait_idle();
    write_reg(CFG_TABLE_BASE, CFG_W'({$urandom, $urandom}));
    run_random(60);

    wait_idle();
    write_reg(CFG_TABLE_BASE, CFG_W'(44'h0));
    write_reg(CFG_VA_LIMIT, CFG_W'(40'h80_0000_0000));
    // drain the pool with fresh top-level slots
    for (int i = 0; i < 10; i++) begin
      send_map(map_req({9'(2 + i * 23), 30'h0}, PA_W'(i) << 12, 32'h1000, 8'h0E));
    end
    req_ch.valid <= 1'b0;
    wait_idle();
    write_reg(CFG_VA_LIMIT, CFG_W'(VA_LIMIT_RST));
    run_random(80);

    wait_idle();
    repeat (64) @(negedge clk);
    if (mappings.errors == 0 && mappings.pending_results.size() == 0) begin
      $display("page_table_mapper_unit_tb: PASS");
    end else begin
      $display("page_table_mapper_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
